/* rtl/urfl_pkg.sv */
package urfl_pkg;

  // Register file
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RegW     = 16;

  typedef enum logic [1:0] {
    RegDivisor = 2'd0,
    RegHeight  = 2'd1,
    RegTimeout = 2'd2,
    RegCap     = 2'd3
  } reg_e;

  localparam logic [RegW-1:0] DivisorRst = 16'd58;
  localparam logic [RegW-1:0] HeightRst  = 16'd100;
  localparam logic [RegW-1:0] TimeoutRst = 16'd30000;
  localparam logic [RegW-1:0] CapRst     = 16'd40000;

  // Trigger pulse shape in ticks
  localparam logic [16:0] LowTicks  = 17'd2;
  localparam logic [16:0] HighTicks = 17'd10;

  // Shared divider: wide enough for (height - distance) * 100
  localparam int unsigned DivW   = 23;
  localparam int unsigned DivCntW = $clog2(DivW + 1);
  localparam logic [6:0]  FillScale = 7'd100;

  typedef struct packed {
    logic       start_req;
    logic [1:0] sensor_select;
    logic [2:0] echo_levels;
  } in_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic        no_echo;
    logic [15:0] distance_cm;
    logic [6:0]  fill_percent;
  } out_t;

endpackage

/* rtl/urfl_div.sv */
module urfl_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [urfl_pkg::DivW-1:0]      dividend_i,
  input  logic [urfl_pkg::RegW-1:0]      divisor_i,
  output logic                           done_o,
  output logic [urfl_pkg::DivW-1:0]      quotient_o
);
  import urfl_pkg::*;

  logic [RegW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [RegW-1:0]    dvs_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [RegW:0]      trial;
  logic [RegW+1:0]    diff;
  logic               fits;

  // One restoring step per cycle: shift in the next dividend bit, try to subtract
  assign trial = {rem_q, quo_q[DivW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign fits  = ~diff[RegW+1];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = DivCntW'(DivW);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? diff[RegW-1:0] : trial[RegW-1:0];
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control under reset, operands load on start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/ultrasonic_range_and_fill_level.sv */
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    in_data_i  (urfl_pkg::in_t)
// out       output     out_valid_o / out_stall_i  out_data_o (urfl_pkg::out_t)
// cfg       input      APB psel/penable/pwrite    paddr, pwdata, prdata
//
// A tick that does not end a measurement is registered in res_q, then moved to the
// output register in SeqOut. A tick that ends a measurement with a nonzero echo width
// runs the shared restoring divider 23 steps for the distance and, unless fill is zero,
// 23 more for the fill percent. The input is stalled while a tick is being worked on.
// rst_ni clears the phase, the sequencer and the registers to their defaults.
// A result waiting on out_stall_i does not block the transfer of the next tick.
module ultrasonic_range_and_fill_level (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  urfl_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output urfl_pkg::out_t                   out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [urfl_pkg::CfgAddrW-1:0]    paddr,
  input  logic [urfl_pkg::CfgDataW-1:0]    pwdata,
  output logic [urfl_pkg::CfgDataW-1:0]    prdata,
  output logic                             pready
);
  import urfl_pkg::*;

  typedef enum logic [2:0] {
    PhIdle, PhLow, PhHigh, PhWait, PhMeasure
  } phase_e;

  typedef enum logic [2:0] {
    SeqIdle, SeqDist, SeqScale, SeqFill, SeqOut
  } seq_e;

  // Configuration registers
  logic [RegW-1:0] divisor_q, height_q, timeout_q, cap_q;
  logic            cfg_wr;
  reg_e            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= DivisorRst;
      height_q  <= HeightRst;
      timeout_q <= TimeoutRst;
      cap_q     <= CapRst;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        RegDivisor: divisor_q <= pwdata[RegW-1:0];
        RegHeight:  height_q  <= pwdata[RegW-1:0];
        RegTimeout: timeout_q <= pwdata[RegW-1:0];
        RegCap:     cap_q     <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegDivisor: prdata = CfgDataW'(divisor_q);
      RegHeight:  prdata = CfgDataW'(height_q);
      RegTimeout: prdata = CfgDataW'(timeout_q);
      RegCap:     prdata = CfgDataW'(cap_q);
      default:    prdata = '0;
    endcase
  end

  // Measurement state and sequencer
  phase_e          phase_q, phase_d;
  logic [16:0]     tick_q, tick_d;
  logic [1:0]      chosen_q, chosen_d;
  seq_e            seq_q, seq_d;
  out_t            res_q, res_d;
  out_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            in_xfer;
  logic            echo;
  logic            finish;
  logic            trig, busy, done, noecho;
  logic [16:0]     width;

  logic            div_start;
  logic [DivW-1:0] div_dividend;
  logic [RegW-1:0] div_divisor;
  logic            div_done;
  logic [DivW-1:0] div_quot;
  logic [RegW-1:0] diff_h;
  logic            fill_zero;

  assign in_stall_o = (seq_q != SeqIdle);
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // Pick the echo line of the sensor latched at start
  always_comb begin
    case (chosen_q)
      2'd0:    echo = in_data_i.echo_levels[0];
      2'd1:    echo = in_data_i.echo_levels[1];
      default: echo = in_data_i.echo_levels[2];
    endcase
  end

  // Advance the measurement by one tick
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    chosen_d = chosen_q;
    trig     = 1'b0;
    busy     = 1'b0;
    done     = 1'b0;
    noecho   = 1'b0;
    finish   = 1'b0;
    width    = tick_q;
    unique case (phase_q)
      PhIdle: begin
        if (in_data_i.start_req) begin
          case (in_data_i.sensor_select)
            2'd1:    chosen_d = 2'd0;
            2'd2:    chosen_d = 2'd1;
            default: chosen_d = 2'd2;
          endcase
          phase_d = PhLow;
          tick_d  = 17'd1;
          busy    = 1'b1;
        end
      end
      PhLow: begin
        busy = 1'b1;
        if (tick_q < LowTicks) begin
          tick_d = tick_q + 17'd1;
        end else begin
          phase_d = PhHigh;
          tick_d  = 17'd1;
          trig    = 1'b1;
        end
      end
      PhHigh: begin
        busy = 1'b1;
        if (tick_q < HighTicks) begin
          tick_d = tick_q + 17'd1;
          trig   = 1'b1;
        end else begin
          phase_d = PhWait;
          tick_d  = '0;
        end
      end
      PhWait: begin
        if (echo) begin
          phase_d = PhMeasure;
          tick_d  = '0;
          busy    = 1'b1;
        end else begin
          tick_d = tick_q + 17'd1;
          if (tick_d >= {1'b0, timeout_q}) begin
            done    = 1'b1;
            noecho  = 1'b1;
            phase_d = PhIdle;
            tick_d  = '0;
          end else begin
            busy = 1'b1;
          end
        end
      end
      PhMeasure: begin
        if (echo && (tick_q <= {1'b0, cap_q})) begin
          tick_d = tick_q + 17'd1;
          busy   = 1'b1;
        end else begin
          finish  = 1'b1;
          done    = 1'b1;
          phase_d = PhIdle;
          tick_d  = '0;
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase
  end

  // Fill is zero when the distance is zero or beyond the bin, or the height is zero
  assign diff_h    = height_q - res_q.distance_cm;
  assign fill_zero = (res_q.distance_cm == '0) || (res_q.distance_cm > height_q) ||
                     (height_q == '0);

  // Feed the shared divider: width / divisor (1 if zero), then (height - distance) * 100 / height unless fill is zero
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DivW'(width);
    div_divisor  = (divisor_q == '0) ? RegW'(1) : divisor_q;
    if (in_xfer && finish && (width != '0)) begin
      div_start = 1'b1;
    end else if (seq_q == SeqScale && !fill_zero) begin
      div_start    = 1'b1;
      div_dividend = DivW'(diff_h) * DivW'(FillScale);
      div_divisor  = height_q;
    end
  end

  always_comb begin
    seq_d       = seq_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (seq_q)
      SeqIdle: begin
        if (in_xfer) begin
          res_d.trigger_level = trig;
          res_d.busy_res      = busy;
          res_d.done_res      = done;
          res_d.no_echo       = noecho;
          res_d.distance_cm   = '0;
          res_d.fill_percent  = '0;
          seq_d = (finish && (width != '0)) ? SeqDist : SeqOut;
        end
      end
      SeqDist: begin
        if (div_done) begin
          res_d.distance_cm = (div_quot[DivW-1:RegW] != '0) ? {RegW{1'b1}} :
                              div_quot[RegW-1:0];
          seq_d = SeqScale;
        end
      end
      SeqScale: begin
        seq_d = fill_zero ? SeqOut : SeqFill;
      end
      SeqFill: begin
        if (div_done) begin
          res_d.fill_percent = div_quot[6:0];
          seq_d = SeqOut;
        end
      end
      SeqOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          seq_d       = SeqIdle;
        end
      end
      default: seq_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      tick_q      <= '0;
      chosen_q    <= '0;
      seq_q       <= SeqIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q  <= phase_d;
        tick_q   <= tick_d;
        chosen_q <= chosen_d;
      end
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  urfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (seq_q == SeqDist || seq_q == SeqFill))
    else $error("divider finished outside a divide step");

  a_xfer_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.fill_percent <= 7'd100))
    else $error("fill percent out of range");

  a_no_echo_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.no_echo) |->
      (out_data_o.done_res && out_data_o.distance_cm == '0 && !out_data_o.busy_res))
    else $error("no-echo result inconsistent");

endmodule
